// File: hdl/tvws_pkg.sv
// ----------------------------------------------------------------------------
// tvws_pkg
// Shared types and constants of the three-voice wavetable sound generator.
// ----------------------------------------------------------------------------
package tvws_pkg;

    localparam int NUM_VOICES  = 3;
    localparam int NIB_W       = 4;
    localparam int REG_DEPTH   = 32;
    localparam int REG_AW      = 5;
    localparam int ADDR_W      = 8;
    localparam int WAVE_DEPTH  = 256;
    localparam int WAVE_AW     = 8;
    localparam int WAVEFORM_W  = 3;
    localparam int FREQ_W      = 20;
    localparam int PHASE_W     = 32;
    localparam int WAVE_IDX_LSB = 25;
    localparam int WAVE_IDX_W  = 5;
    localparam int OUT_W       = 10;
    localparam int PROD_W      = 9;

    // Sound register map
    localparam int VOICE_STRIDE      = 5;
    localparam int REG_WAVEFORM_BASE = 'h05;
    localparam int REG_FREQ_LOW      = 'h10;
    localparam int REG_FREQ_BASE     = 'h11;
    localparam int REG_VOLUME_BASE   = 'h15;

    typedef enum logic [1:0] {
        ACT_REG_WR  = 2'd0,
        ACT_WAVE_WR = 2'd1,
        ACT_TICK    = 2'd2
    } action_t;

    typedef struct packed {
        logic [WAVEFORM_W-1:0] waveform;
        logic [NIB_W-1:0]      volume;
        logic [FREQ_W-1:0]     freq;
        logic                  active;
    } voice_cfg_t;

endpackage

// File: hdl/tvws_regfile.sv
// ----------------------------------------------------------------------------
// tvws_regfile
// 32-entry sound register file with per-voice field decode.
// ----------------------------------------------------------------------------
module tvws_regfile
    import tvws_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  logic [ADDR_W-1:0]  wr_addr,
    input  logic [NIB_W-1:0]   wr_data,
    output voice_cfg_t         voice_cfg [NUM_VOICES]
);

    logic [NIB_W-1:0] regs_reg [REG_DEPTH];

    // Writes above the register range drop silently
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < REG_DEPTH; i++) begin
                regs_reg[i] <= '0;
            end
        end else if (wr_en && (wr_addr[ADDR_W-1:REG_AW] == '0)) begin
            regs_reg[wr_addr[REG_AW-1:0]] <= wr_data;
        end
    end

    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
        localparam logic [REG_AW-1:0] IdxWave =
            REG_AW'(REG_WAVEFORM_BASE + VOICE_STRIDE * v);
        localparam logic [REG_AW-1:0] IdxVol =
            REG_AW'(REG_VOLUME_BASE + VOICE_STRIDE * v);
        localparam logic [REG_AW-1:0] IdxF1 =
            REG_AW'(REG_FREQ_BASE + VOICE_STRIDE * v);
        localparam logic [REG_AW-1:0] IdxF2 =
            REG_AW'(REG_FREQ_BASE + 1 + VOICE_STRIDE * v);
        localparam logic [REG_AW-1:0] IdxF3 =
            REG_AW'(REG_FREQ_BASE + 2 + VOICE_STRIDE * v);
        localparam logic [REG_AW-1:0] IdxF4 =
            REG_AW'(REG_FREQ_BASE + 3 + VOICE_STRIDE * v);
        localparam logic [REG_AW-1:0] IdxLow = REG_AW'(REG_FREQ_LOW);

        logic [NIB_W-1:0]  low_nib;
        logic [FREQ_W-1:0] freq;

        // Only voice 0 owns the lowest frequency nibble
        assign low_nib = (v == 0) ? regs_reg[IdxLow] : '0;
        assign freq    = {regs_reg[IdxF4], regs_reg[IdxF3], regs_reg[IdxF2],
                          regs_reg[IdxF1], low_nib};

        // Fields in order: waveform, volume, frequency, active
        assign voice_cfg[v] = {regs_reg[IdxWave][WAVEFORM_W-1:0],
                               regs_reg[IdxVol],
                               freq,
                               (regs_reg[IdxVol] != '0) && (freq != '0)};
    end

endmodule

// File: hdl/tvws_wave_ram.sv
// ----------------------------------------------------------------------------
// tvws_wave_ram
// 256 x 4 wave store, one write port and one registered read port.
// ----------------------------------------------------------------------------
module tvws_wave_ram
    import tvws_pkg::*;
(
    input  logic               aclk,
    input  logic               wr_en,
    input  logic [WAVE_AW-1:0] wr_addr,
    input  logic [NIB_W-1:0]   wr_data,
    input  logic               rd_en,
    input  logic [WAVE_AW-1:0] rd_addr,
    output logic [NIB_W-1:0]   rd_data
);

    logic [NIB_W-1:0] mem [WAVE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read returns the old word on a same-cycle write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/tvws_mixer.sv
// ----------------------------------------------------------------------------
// tvws_mixer
// Weight each voice's signed wave sample by its volume and sum the voices.
// ----------------------------------------------------------------------------
module tvws_mixer
    import tvws_pkg::*;
(
    input  logic [NIB_W-1:0]        wave_nib [NUM_VOICES],
    input  logic [NIB_W-1:0]        volume   [NUM_VOICES],
    input  logic                    active   [NUM_VOICES],
    output logic signed [OUT_W-1:0] mix
);

    logic signed [NIB_W-1:0]  sample [NUM_VOICES];
    logic signed [PROD_W-1:0] samp_ext [NUM_VOICES];
    logic signed [PROD_W-1:0] vol_ext [NUM_VOICES];
    logic signed [PROD_W-1:0] prod [NUM_VOICES];

    always_comb begin
        mix = '0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            // Stored nibble minus bias: flip the top bit
            sample[v]   = signed'({~wave_nib[v][NIB_W-1], wave_nib[v][NIB_W-2:0]});
            samp_ext[v] = PROD_W'(sample[v]);
            vol_ext[v]  = signed'({{(PROD_W-NIB_W){1'b0}}, volume[v]});
            prod[v]     = active[v] ? (samp_ext[v] * vol_ext[v]) : '0;
            mix         = mix + OUT_W'(prod[v]);
        end
    end

endmodule

// File: hdl/three_voice_wavetable_sound.sv
// ----------------------------------------------------------------------------
// three_voice_wavetable_sound
// A tick's result passes the input, phase and mix stages, then the output register.
// Throughput: one item per cycle unless the output stalls; writes retire in the input stage.
// The three wave store copies and the phase registers set this staged flow.
// Reset (aresetn low, synchronous): registers, phases, scale, valids cleared.
// The wave store is not cleared and holds garbage until written.
// ----------------------------------------------------------------------------
module three_voice_wavetable_sound
    import tvws_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [PHASE_W-1:0]      cfg_wr_data,
    // input items
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [1:0]              s_action,
    input  logic [ADDR_W-1:0]       s_write_addr,
    input  logic [NIB_W-1:0]        s_write_data,
    // results
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_mixed_sample
);

    // ------------------------------------------------------------------
    // Stage enables: each stage moves when the next one is empty or moving
    // ------------------------------------------------------------------
    logic en_out, en3, en2, en1;

    logic                    in_v_reg;
    action_t                 in_action_reg;
    logic [ADDR_W-1:0]       in_addr_reg;
    logic [NIB_W-1:0]        in_data_reg;

    logic                    v2_reg;
    logic                    v3_reg;
    logic                    out_v_reg;
    logic signed [OUT_W-1:0] out_sample_reg;

    logic [PHASE_W-1:0]      phase_scale_reg;

    assign en_out  = !out_v_reg || m_ready;
    assign en3     = !v3_reg || en_out;
    assign en2     = !v2_reg || en3;
    assign en1     = !in_v_reg || en2;
    assign s_ready = en1;

    // Scale register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_scale_reg <= '0;
        end else if (cfg_wr_en) begin
            phase_scale_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register; writes take effect as the item leaves
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (en1) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1 && s_valid) begin
            in_action_reg <= action_t'(s_action);
            in_addr_reg   <= s_write_addr;
            in_data_reg   <= s_write_data;
        end
    end

    logic s1_fire;
    logic reg_wr, wave_wr, tick1;

    assign s1_fire = in_v_reg && en2;

    always_comb begin
        reg_wr  = 1'b0;
        wave_wr = 1'b0;
        tick1   = 1'b0;
        case (in_action_reg)
            ACT_REG_WR:  reg_wr  = s1_fire;
            ACT_WAVE_WR: wave_wr = s1_fire;
            ACT_TICK:    tick1   = s1_fire;
            default: ;  // unused code: drop the item
        endcase
    end

    voice_cfg_t voice_cfg [NUM_VOICES];

    tvws_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (reg_wr),
        .wr_addr   (in_addr_reg),
        .wr_data   (in_data_reg),
        .voice_cfg (voice_cfg)
    );

    // Phase step per voice: frequency times scale, low 32 bits
    logic [PHASE_W-1:0] step1 [NUM_VOICES];

    always_comb begin
        for (int v = 0; v < NUM_VOICES; v++) begin
            step1[v] = PHASE_W'(voice_cfg[v].freq) * phase_scale_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: phase read, wave lookup address, phase advance
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0]    step2_reg     [NUM_VOICES];
    logic [WAVEFORM_W-1:0] waveform2_reg [NUM_VOICES];
    logic [NIB_W-1:0]      volume2_reg   [NUM_VOICES];
    logic                  active2_reg   [NUM_VOICES];
    logic [PHASE_W-1:0]    phase_reg     [NUM_VOICES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= tick1;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick1) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                step2_reg[v]     <= step1[v];
                waveform2_reg[v] <= voice_cfg[v].waveform;
                volume2_reg[v]   <= voice_cfg[v].volume;
                active2_reg[v]   <= voice_cfg[v].active;
            end
        end
    end

    logic s2_fire;
    assign s2_fire = v2_reg && en3;

    // Advance only sounding voices; the lookup uses the phase before the add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                phase_reg[v] <= '0;
            end
        end else if (s2_fire) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                if (active2_reg[v]) begin
                    phase_reg[v] <= phase_reg[v] + step2_reg[v];
                end
            end
        end
    end

    // One wave store copy per voice so all three look up in the same cycle
    logic [NIB_W-1:0] wave_nib3 [NUM_VOICES];

    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_wave
        logic [WAVE_AW-1:0] rd_addr;

        assign rd_addr = {waveform2_reg[v],
                          phase_reg[v][WAVE_IDX_LSB +: WAVE_IDX_W]};

        tvws_wave_ram u_wave_ram (
            .aclk    (aclk),
            .wr_en   (wave_wr),
            .wr_addr (in_addr_reg),
            .wr_data (in_data_reg),
            .rd_en   (s2_fire),
            .rd_addr (rd_addr),
            .rd_data (wave_nib3[v])
        );
    end

    // ------------------------------------------------------------------
    // Stage 3: weight and mix, then into the output register
    // ------------------------------------------------------------------
    logic [NIB_W-1:0] volume3_reg [NUM_VOICES];
    logic             active3_reg [NUM_VOICES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_fire) begin
            for (int v = 0; v < NUM_VOICES; v++) begin
                volume3_reg[v] <= volume2_reg[v];
                active3_reg[v] <= active2_reg[v];
            end
        end
    end

    logic signed [OUT_W-1:0] mix3;

    tvws_mixer u_mixer (
        .wave_nib (wave_nib3),
        .volume   (volume3_reg),
        .active   (active3_reg),
        .mix      (mix3)
    );

    // Output register: hold the result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en_out) begin
            out_v_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && v3_reg) begin
            out_sample_reg <= mix3;
        end
    end

    assign m_valid        = out_v_reg;
    assign m_mixed_sample = out_sample_reg;

endmodule

// File: verif/three_voice_wavetable_sound_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// three_voice_wavetable_sound_tb
// Self-checking bench for the three-voice wavetable sound generator. It loads
// the wave store, runs a short directed sweep through the sum extremes, the
// inactive voices, the ignored register writes and the unused action, and then
// feeds random register, wave and tick items under several phase scales. An
// in-bench voice mixer predicts every sample at the input transfer. The result
// side compares each sample with the oldest prediction. Both sides stall at
// random.
// ----------------------------------------------------------------------------
module three_voice_wavetable_sound_tb;
    import tvws_pkg::*;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int         MAX_REPORTS = 10;
    localparam int         DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] addr;
        logic [NIB_W-1:0]  data;
    } sound_item_t;

    // ------------------------------------------------------------------------
    // DUT signals, the driven ones known from time zero
    // ------------------------------------------------------------------------
    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [PHASE_W-1:0]      cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_action = '0;
    logic [ADDR_W-1:0]       s_write_addr = '0;
    logic [NIB_W-1:0]        s_write_data = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_mixed_sample;

    three_voice_wavetable_sound i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_write_addr   (s_write_addr),
        .s_write_data   (s_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_mixed_sample (m_mixed_sample)
    );

    // ------------------------------------------------------------------------
    // Bench state: stimulus queue, mixer shadow state, expected samples
    // ------------------------------------------------------------------------
    sound_item_t             pending_items[$];
    logic signed [OUT_W-1:0] expected_samples[$];

    logic [NIB_W-1:0]        sound_regs[REG_DEPTH];
    logic [NIB_W-1:0]        wave_nibbles[WAVE_DEPTH];
    logic [PHASE_W-1:0]      voice_phase[NUM_VOICES];
    logic [PHASE_W-1:0]      phase_scale_q;

    int  error_count = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  send_calm = 1'b0;
    bit  recv_calm = 1'b0;

    // Clock: 10 ns period
    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Voice mixer: sum the active voices at their current phase, then advance
    // each active phase by frequency * scale, wrapping at 32 bits.
    // ------------------------------------------------------------------------
    function automatic logic signed [OUT_W-1:0] mix_voices();
        voice_cfg_t      vc;
        int              b;
        int              acc;
        logic [7:0]      widx;
        logic [PHASE_W-1:0] step;
        acc = 0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            b           = VOICE_STRIDE * v;
            vc.waveform = sound_regs[REG_WAVEFORM_BASE + b][WAVEFORM_W-1:0];
            vc.volume   = sound_regs[REG_VOLUME_BASE + b];
            // only voice 0 owns the lowest frequency nibble
            vc.freq     = {sound_regs[REG_FREQ_BASE + 3 + b],
                           sound_regs[REG_FREQ_BASE + 2 + b],
                           sound_regs[REG_FREQ_BASE + 1 + b],
                           sound_regs[REG_FREQ_BASE + b],
                           (v == 0) ? sound_regs[REG_FREQ_LOW] : 4'h0};
            vc.active   = (vc.volume != 0) && (vc.freq != 0);
            if (vc.active) begin
                // sample is taken before the phase moves
                widx = {vc.waveform, voice_phase[v][WAVE_IDX_LSB +: WAVE_IDX_W]};
                acc  = acc + (int'(wave_nibbles[widx]) - 8) * int'(vc.volume);
                step = phase_scale_q * {{(PHASE_W-FREQ_W){1'b0}}, vc.freq};
                voice_phase[v] = voice_phase[v] + step;
            end
        end
        return acc[OUT_W-1:0];
    endfunction

    // Apply one transferred item to the shadow state; queue a sample on a tick
    task automatic absorb_item(input sound_item_t it);
        case (it.action)
            ACT_REG_WR: begin
                // addresses above the register file are dropped
                if (it.addr < REG_DEPTH)
                    sound_regs[it.addr[REG_AW-1:0]] = it.data;
            end
            ACT_WAVE_WR: begin
                wave_nibbles[it.addr] = it.data;
            end
            ACT_TICK: begin
                expected_samples.push_back(mix_voices());
            end
            default: ;
        endcase
    endtask

    // Idle length: mostly none, some short, a few long; none in calm stretches
    function automatic int idle_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic report_error(input string msg);
        if (error_count < MAX_REPORTS)
            $display("[%0t] ERROR: %s", $realtime, msg);
        error_count++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: present queued items, hold each until its transfer, predict on
    // the transfer edge from the payload still on the port.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : item_driver
        sound_item_t nxt;
        sound_item_t cur;
        bit          hold;
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            hold = s_valid && !s_ready;
            if (s_valid && s_ready) begin
                cur.action = s_action;
                cur.addr   = s_write_addr;
                cur.data   = s_write_data;
                absorb_item(cur);
                // flip between stalling and calm stretches now and then
                if ($urandom_range(0, 149) == 0)
                    send_calm <= !send_calm;
            end
            if (!hold) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt          = pending_items.pop_front();
                    s_valid      <= 1'b1;
                    s_action     <= nxt.action;
                    s_write_addr <= nxt.addr;
                    s_write_data <= nxt.data;
                    send_gap     <= idle_len(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random backpressure, compare each result transfer in order
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : sample_monitor
        logic signed [OUT_W-1:0] want;
        if (!aresetn) begin
            m_ready  <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_error($sformatf("unexpected sample %0d", m_mixed_sample));
                end else begin
                    want = expected_samples.pop_front();
                    if (m_mixed_sample !== want)
                        report_error($sformatf("mixed_sample expected %0d got %0d",
                                               want, m_mixed_sample));
                end
                if ($urandom_range(0, 59) == 0)
                    recv_calm <= !recv_calm;
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready  <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_gap <= idle_len(recv_calm);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                             input logic [NIB_W-1:0] data);
        sound_item_t it;
        it.action = act;
        it.addr   = addr;
        it.data   = data;
        pending_items.push_back(it);
    endtask

    // Wait until every item is transferred and every sample is back, then let
    // the pipeline drain. Checked on the falling edge so all updates settled.
    task automatic wait_until_idle();
        while (pending_items.size() != 0 || s_valid || expected_samples.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_phase_scale(input logic [PHASE_W-1:0] val);
        wait_until_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en     <= 1'b0;
        phase_scale_q = val;
        @(negedge aclk);
    endtask

    // Random traffic: mostly ticks and register writes inside the file, with
    // wave rewrites, out-of-range register writes and the unused action mixed in.
    task automatic queue_random_items(input int count);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
                push_item(ACT_TICK, ADDR_W'($urandom), NIB_W'($urandom));
            else if (r < 75)
                push_item(ACT_REG_WR, ADDR_W'($urandom_range(0, REG_DEPTH - 1)),
                          NIB_W'($urandom));
            else if (r < 79)
                push_item(ACT_REG_WR, ADDR_W'($urandom_range(REG_DEPTH, 255)),
                          NIB_W'($urandom));
            else if (r < 95)
                push_item(ACT_WAVE_WR, ADDR_W'($urandom), NIB_W'($urandom));
            else
                push_item(ACT_UNUSED, ADDR_W'($urandom), NIB_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------------
    // Reset and test sequence
    // ------------------------------------------------------------------------
    initial begin : test_sequence
        logic [PHASE_W-1:0] scales[7];

        foreach (sound_regs[i])   sound_regs[i] = '0;
        foreach (wave_nibbles[i]) wave_nibbles[i] = '0;
        foreach (voice_phase[i])  voice_phase[i] = '0;
        phase_scale_q = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill the whole wave store so no tick ever reads an unwritten entry
        for (int a = 0; a < WAVE_DEPTH; a++)
            push_item(ACT_WAVE_WR, ADDR_W'(a), NIB_W'($urandom));

        // Directed part, scale still at its reset value so phases stay at 0.
        // All voices silent right after reset.
        push_item(ACT_TICK, 8'h00, 4'h0);
        // Most negative sum: every voice at full volume on a nibble of 0
        push_item(ACT_WAVE_WR, 8'd0, 4'h0);
        push_item(ACT_WAVE_WR, 8'd224, 4'hF);
        push_item(ACT_REG_WR, ADDR_W'(REG_VOLUME_BASE), 4'hF);
        push_item(ACT_REG_WR, ADDR_W'(REG_VOLUME_BASE + VOICE_STRIDE), 4'hF);
        push_item(ACT_REG_WR, ADDR_W'(REG_VOLUME_BASE + 2 * VOICE_STRIDE), 4'hF);
        // voice 0 runs on its lowest nibble alone
        push_item(ACT_REG_WR, ADDR_W'(REG_FREQ_LOW), 4'h1);
        push_item(ACT_REG_WR, ADDR_W'(REG_FREQ_BASE + 3 + VOICE_STRIDE), 4'hF);
        push_item(ACT_REG_WR, ADDR_W'(REG_FREQ_BASE + 2 * VOICE_STRIDE), 4'h1);
        push_item(ACT_TICK, 8'hFF, 4'hF);
        // Most positive sum: waveform 7 (upper register bit masked off)
        push_item(ACT_REG_WR, ADDR_W'(REG_WAVEFORM_BASE), 4'hF);
        push_item(ACT_REG_WR, ADDR_W'(REG_WAVEFORM_BASE + VOICE_STRIDE), 4'hF);
        push_item(ACT_REG_WR, ADDR_W'(REG_WAVEFORM_BASE + 2 * VOICE_STRIDE), 4'hF);
        push_item(ACT_TICK, 8'h00, 4'h0);
        // Register writes past the file and the unused action change nothing
        push_item(ACT_REG_WR, 8'h2F, 4'h0);
        push_item(ACT_REG_WR, 8'hFF, 4'h0);
        push_item(ACT_UNUSED, ADDR_W'(REG_VOLUME_BASE), 4'h0);
        push_item(ACT_TICK, 8'h55, 4'hA);
        // Silence voice 1 by volume, then voice 2 by frequency
        push_item(ACT_REG_WR, ADDR_W'(REG_VOLUME_BASE + VOICE_STRIDE), 4'h0);
        push_item(ACT_TICK, 8'hAA, 4'h5);
        push_item(ACT_REG_WR, ADDR_W'(REG_FREQ_BASE + 2 * VOICE_STRIDE), 4'h0);
        push_item(ACT_TICK, 8'h00, 4'h0);

        // Random part under a sweep of phase scales, extremes included
        scales[0] = 32'hFFFF_FFFF;
        scales[1] = 32'h0000_0001;
        scales[2] = PHASE_W'($urandom);
        scales[3] = 32'h8000_0000;
        scales[4] = PHASE_W'($urandom_range(1, 1 << 14));
        scales[5] = 32'h0000_0000;
        scales[6] = PHASE_W'($urandom);
        foreach (scales[k]) begin
            set_phase_scale(scales[k]);
            queue_random_items(232);
        end

        wait_until_idle();
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
